FILE: src/arp_pkg.sv
// ---------------------------------------------------------------------------
// arp_pkg: shared types and constants for the AT response parser
// Character codes, status codes and the per-beat result record.
// ---------------------------------------------------------------------------
package arp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  // byte window kept inside an info line (inclusive, 32 to 128)
  localparam logic [7:0] CH_KEEP_LO = 8'd32;
  localparam logic [7:0] CH_KEEP_HI = 8'd128;

  localparam logic [1:0] ST_NOT_READY = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  localparam int unsigned RES_W = 30;   // packed result width
  localparam int unsigned TDATA_OUT_W = 32;
  localparam int unsigned TDATA_IN_W  = 16;

  // field order matches the output beat layout, lowest field last
  typedef struct packed {
    logic [7:0] store_char;
    logic [6:0] store_col;
    logic [4:0] store_line;
    logic       store_valid;
    logic [5:0] lines_held;
    logic       final_is_ok;
    logic [1:0] status;
  } result_t;

endpackage

FILE: src/arp_engine.sv
// ---------------------------------------------------------------------------
// arp_engine: response grammar state machine
// Holds parse state, column and line counters; decides one byte per cycle while advance is high.
// ---------------------------------------------------------------------------
module arp_engine #(
  parameter int unsigned MAX_LINES = 32,
  parameter int unsigned LINE_SIZE = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  input  logic             force_info_line,
  output arp_pkg::result_t res
);
  import arp_pkg::*;

  localparam int unsigned LT_W  = $clog2(MAX_LINES + 1);
  localparam int unsigned COL_W = $clog2(LINE_SIZE + 1);
  localparam logic [LT_W-1:0]  LT_MAX  = LT_W'(MAX_LINES);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_SIZE);

  typedef enum logic [4:0] {
    S_WAIT_CR    = 5'd0,
    S_OPEN_LF    = 5'd1,
    S_FIRST      = 5'd2,
    S_OK_K       = 5'd3,
    S_OK_CR      = 5'd4,
    S_OK_LF      = 5'd5,
    S_ER_R1      = 5'd6,
    S_ER_R2      = 5'd7,
    S_ER_O       = 5'd8,
    S_ER_R3      = 5'd9,
    S_ER_CR      = 5'd10,
    S_ER_LF      = 5'd11,
    S_INFO       = 5'd12,
    S_INFO_LF    = 5'd13,
    S_AFTER_INFO = 5'd14,
    S_SEP_LF     = 5'd15,
    S_FINAL      = 5'd16
  } state_t;

  state_t          state, state_next;
  logic [COL_W-1:0] column, column_next;
  logic [LT_W-1:0]  line_total, line_total_next;
  logic             line_dropped, line_dropped_next;

  logic             open_req;   // byte starts a new info line
  logic             keep_req;   // byte belongs to the current info line
  logic [1:0]       status;
  logic             ok_flag;
  logic             store_ok;
  logic [COL_W-1:0] col_eff;
  logic [LT_W-1:0]  lt_eff;
  logic             drop_eff;
  logic [LT_W-1:0]  line_idx;
  logic [LT_W+5:0]  lines_wide;
  logic [LT_W+4:0]  line_wide;
  logic [COL_W+6:0] col_wide;
  logic             in_keep_range;

  assign in_keep_range = (rx_byte >= CH_KEEP_LO) && (rx_byte <= CH_KEEP_HI);

  // grammar decode
  always_comb begin
    state_next      = state;
    status          = ST_NOT_READY;
    ok_flag         = 1'b0;
    open_req        = 1'b0;
    keep_req        = 1'b0;
    line_total_next = line_total;
    case (state)
      S_OPEN_LF: begin
        if (rx_byte == CH_LF) state_next = S_FIRST; else status = ST_ERROR;
      end
      S_FIRST: begin
        if (force_info_line || rx_byte == CH_PLUS) begin
          open_req   = 1'b1;
          state_next = S_INFO;
        end else if (rx_byte == CH_O) begin
          state_next = S_OK_K;
        end else if (rx_byte == CH_E) begin
          state_next = S_ER_R1;
        end else begin
          status = ST_ERROR;
        end
      end
      S_OK_K: begin
        if (rx_byte == CH_K) state_next = S_OK_CR; else status = ST_ERROR;
      end
      S_OK_CR: begin
        if (rx_byte == CH_CR) state_next = S_OK_LF; else status = ST_ERROR;
      end
      S_OK_LF: begin
        if (rx_byte == CH_LF) begin
          status  = ST_DONE;
          ok_flag = 1'b1;
        end else begin
          status = ST_ERROR;
        end
      end
      S_ER_R1: begin
        if (rx_byte == CH_R) state_next = S_ER_R2; else status = ST_ERROR;
      end
      S_ER_R2: begin
        if (rx_byte == CH_R) state_next = S_ER_O; else status = ST_ERROR;
      end
      S_ER_O: begin
        if (rx_byte == CH_O) state_next = S_ER_R3; else status = ST_ERROR;
      end
      S_ER_R3: begin
        if (rx_byte == CH_R) state_next = S_ER_CR; else status = ST_ERROR;
      end
      S_ER_CR: begin
        if (rx_byte == CH_CR) state_next = S_ER_LF; else status = ST_ERROR;
      end
      S_ER_LF: begin
        if (rx_byte == CH_LF) status = ST_DONE; else status = ST_ERROR;
      end
      S_INFO: begin
        if (in_keep_range) begin
          keep_req = 1'b1;
        end else if (rx_byte == CH_CR) begin
          keep_req   = 1'b1;
          state_next = S_INFO_LF;
        end else begin
          status = ST_ERROR;
        end
      end
      S_INFO_LF: begin
        if (rx_byte == CH_LF) begin
          keep_req   = 1'b1;
          state_next = S_AFTER_INFO;
        end else begin
          status = ST_ERROR;
        end
      end
      S_AFTER_INFO: begin
        if (force_info_line && rx_byte != CH_CR) begin
          status = ST_ERROR;
        end else if (rx_byte == CH_PLUS) begin
          open_req   = 1'b1;
          state_next = S_INFO;
        end else if (rx_byte == CH_CR) begin
          state_next = S_SEP_LF;
        end else begin
          status = ST_ERROR;
        end
      end
      S_SEP_LF: begin
        if (rx_byte == CH_LF) state_next = S_FINAL; else status = ST_ERROR;
      end
      S_FINAL: begin
        if (rx_byte == CH_O) state_next = S_OK_K;
        else if (rx_byte == CH_E) state_next = S_ER_R1;
        else status = ST_ERROR;
      end
      default: begin
        // idle: every byte here forgets earlier lines
        line_total_next = '0;
        state_next      = (rx_byte == CH_CR) ? S_OPEN_LF : S_WAIT_CR;
      end
    endcase
    if (open_req && line_total < LT_MAX) line_total_next = line_total + 1'b1;
    // a final status of either kind restarts the parser
    if (status != ST_NOT_READY) state_next = S_WAIT_CR;
  end

  // line bookkeeping: opening a line resets the column before its first byte
  always_comb begin
    col_eff  = column;
    drop_eff = line_dropped;
    lt_eff   = line_total_next;
    if (open_req) begin
      col_eff  = '0;
      drop_eff = (line_total >= LT_MAX);
    end
    store_ok = (open_req && !drop_eff) || keep_req;
    store_ok = store_ok && !drop_eff && (lt_eff != '0) && (col_eff < COL_MAX);

    column_next       = store_ok ? col_eff + 1'b1 : col_eff;
    line_dropped_next = drop_eff;
    if (status != ST_NOT_READY) begin
      column_next = '0;
    end
  end

  assign line_idx   = lt_eff - 1'b1;
  assign lines_wide = {6'd0, line_total_next};
  assign line_wide  = {5'd0, line_idx};
  assign col_wide   = {7'd0, col_eff};

  always_comb begin
    res.status      = status;
    res.final_is_ok = ok_flag;
    res.lines_held  = lines_wide[5:0];
    res.store_valid = store_ok;
    res.store_line  = store_ok ? line_wide[4:0] : 5'd0;
    res.store_col   = store_ok ? col_wide[6:0] : 7'd0;
    res.store_char  = store_ok ? rx_byte : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WAIT_CR;
      column       <= '0;
      line_total   <= '0;
      line_dropped <= 1'b0;
    end else if (advance) begin
      state        <= state_next;
      column       <= column_next;
      line_total   <= line_total_next;
      line_dropped <= line_dropped_next;
    end
  end

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    advance && status != ST_NOT_READY |=> state == S_WAIT_CR && column == '0)
    else $error("parser did not restart after a final status");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    line_total <= LT_MAX && column <= COL_MAX)
    else $error("line or column counter out of range");

  a_store_line: assert property (@(posedge clk) disable iff (rst)
    advance && store_ok |=> line_total != '0 && !line_dropped)
    else $error("byte stored without an open line");

  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    advance && state == S_WAIT_CR |=> line_total == '0)
    else $error("idle byte did not clear the line count");

endmodule

FILE: src/arp_out_stage.sv
// ---------------------------------------------------------------------------
// arp_out_stage: result register of the parser
// Holds one result beat; reloads in the cycle its beat is taken.
// ---------------------------------------------------------------------------
module arp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  arp_pkg::result_t load_data,
  output logic             can_load,
  output logic             m_tvalid,
  input  logic             m_tready,
  output arp_pkg::result_t m_data
);
  import arp_pkg::*;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) m_data <= load_data;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_data))
    else $error("result beat changed while stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load && !can_load |=> m_tvalid)
    else $error("load attempted into a full result register");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && can_load |=> m_tvalid)
    else $error("loaded result not presented");

endmodule

FILE: src/at_response_parser.sv
// ---------------------------------------------------------------------------
// at_response_parser: AT command response checker
// Parses CR LF [+info CR LF ... CR LF] OK|ERROR CR LF one byte per beat,
// reports status per byte and emits line/column/char writes for info lines.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | one received byte plus force_info_line flag
//  m_*     | out | status, OK flag, line count and the store write for it
//
//  One byte per cycle sustained while m_tready stays high; after its s-side
//  accept the result beat passes the input register, then the result register.
//  The grammar decision is a single pass of next-state logic in arp_engine.
//  rst is synchronous: parser returns to waiting for CR, counts clear,
//  both register stages empty.
//  A stalled m side holds its beat; the input register still takes one more
//  byte, then s_tready drops until the result register frees up.
// ---------------------------------------------------------------------------
module at_response_parser #(
  parameter int unsigned MAX_LINES = 32,
  parameter int unsigned LINE_SIZE = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] rx_byte, [8] force_info_line, [15:9] zero
  input  logic [arp_pkg::TDATA_IN_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] status, [2] final_is_ok, [8:3] lines_held, [9] store_valid,
  // [14:10] store_line, [21:15] store_col, [29:22] store_char, [31:30] zero
  output logic [arp_pkg::TDATA_OUT_W-1:0]     m_tdata
);
  import arp_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_force;
  logic       advance;     // input beat moves into the result register
  logic       can_load;

  result_t    step_res;
  result_t    out_res;

  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata[7:0];
      in_force <= s_tdata[8];
    end
  end

  // grammar state machine; its state commits only when the beat moves on
  arp_engine #(
    .MAX_LINES (MAX_LINES),
    .LINE_SIZE (LINE_SIZE)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .rx_byte         (in_byte),
    .force_info_line (in_force),
    .res             (step_res)
  );

  arp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_valid),
    .load_data (step_res),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_data    (out_res)
  );

  assign m_tdata = {2'b00, out_res};

  a_in_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_force))
    else $error("pending input beat lost");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && !can_load |-> !s_tready)
    else $error("input accepted with both stages full");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("advanced beat missing at output");

endmodule
